FILE: rtl/aar_pkg.sv
// aar_pkg: widths, fixed-point constants and the CORDIC arctangent table
// for the axis-angle rotation matrix pipeline. No dependencies.
package aar_pkg;

    localparam int NCOMP        = 3;     // axis components
    localparam int IN_W         = 16;    // input field width
    localparam int ENTRY_W      = 16;    // matrix entry width (Q1.14)
    localparam int SQ_W         = 31;    // square of one component
    localparam int SUM_W        = 32;    // sum of squares
    localparam int DIV_STEPS    = 29;    // quotient bits of v^2*2^28/S
    localparam int QUO_W        = 29;
    localparam int SQRT_STEPS   = 15;    // root bits
    localparam int RES_W        = 29;    // sqrt working register
    localparam int NORM_W       = 15;    // |n| <= 2^14
    localparam int N_W          = 16;    // signed unit component
    localparam int CORDIC_STEPS = 16;
    localparam int CW           = 34;    // CORDIC datapath, Q.30
    localparam int ANG_SHIFT    = 17;    // Q3.13 -> Q.30
    localparam int C_W          = 18;    // sine, cosine, 1-cos in Q.14
    localparam int PROD_W       = 34;    // n*n and n*s products
    localparam int Q42_W        = 48;    // entry accumulators

    localparam logic signed [CW-1:0] PI_Q30      = 34'sd3373259426;
    localparam logic signed [CW-1:0] HALF_PI_Q30 = 34'sd1686629713;
    localparam logic signed [CW-1:0] GAIN_Q30    = 34'sd652032874;
    localparam logic signed [C_W-1:0] ONE_Q14    = 18'sd16384;

    // Latencies in pipeline stages
    localparam int NORM_LAT   = DIV_STEPS + SQRT_STEPS;
    localparam int CORDIC_LAT = CORDIC_STEPS + 1;

    typedef logic [SQ_W-1:0]   sq_t;
    typedef logic [SUM_W-1:0]  sum_t;
    typedef logic [NORM_W-1:0] mag_t;

    function automatic logic signed [CW-1:0] atan_q30(input int k);
        logic signed [CW-1:0] a;
        case (k)
            0:       a = 34'sh3243F6A8;
            1:       a = 34'sh1DAC6705;
            2:       a = 34'sh0FADBAFC;
            3:       a = 34'sh07F56EA6;
            4:       a = 34'sh03FEAB76;
            5:       a = 34'sh01FFD55B;
            6:       a = 34'sh00FFFAAA;
            7:       a = 34'sh007FFF55;
            8:       a = 34'sh003FFFEA;
            9:       a = 34'sh001FFFFD;
            10:      a = 34'sh000FFFFF;
            11:      a = 34'sh0007FFFF;
            12:      a = 34'sh0003FFFF;
            13:      a = 34'sh0001FFFF;
            14:      a = 34'sh0000FFFF;
            15:      a = 34'sh00007FFF;
            default: a = '0;
        endcase
        return a;
    endfunction

endpackage

FILE: rtl/axis_angle_rotation_matrix.sv
// axis_angle_rotation_matrix: top level, Rodrigues rotation matrix from an
// angle and an axis. Uses aar_pkg, aar_norm (axis normalize), aar_cordic.
//
//   channel | ports                               | transaction
//   --------+-------------------------------------+-----------------------------
//   input   | s_valid s_ready s_angle s_axis_*    | angle Q3.13 plus raw axis
//   output  | m_valid m_ready m_entry_r*_c* flag  | nine Q1.14 entries plus flag
//
// One transaction enters per cycle while the pipe advances; a stall holds
// the input back. The pipe depth is set by the normalize path: 29 divider
// stages plus 15 square root stages, with 3 stages in front and 4 behind.
// Reset (aresetn low, synchronous) clears every valid bit; no data is reset.
// The whole pipe advances on one enable: it holds when the output register
// is full and m_ready is low, so a stall neither drops nor repeats anything.
module axis_angle_rotation_matrix import aar_pkg::*; (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      s_valid,
    output logic                      s_ready,
    input  logic signed [IN_W-1:0]    s_angle,
    input  logic signed [IN_W-1:0]    s_axis_x,
    input  logic signed [IN_W-1:0]    s_axis_y,
    input  logic signed [IN_W-1:0]    s_axis_z,
    output logic                      m_valid,
    input  logic                      m_ready,
    output logic signed [ENTRY_W-1:0] m_entry_r0_c0,
    output logic signed [ENTRY_W-1:0] m_entry_r0_c1,
    output logic signed [ENTRY_W-1:0] m_entry_r0_c2,
    output logic signed [ENTRY_W-1:0] m_entry_r1_c0,
    output logic signed [ENTRY_W-1:0] m_entry_r1_c1,
    output logic signed [ENTRY_W-1:0] m_entry_r1_c2,
    output logic signed [ENTRY_W-1:0] m_entry_r2_c0,
    output logic signed [ENTRY_W-1:0] m_entry_r2_c1,
    output logic signed [ENTRY_W-1:0] m_entry_r2_c2,
    output logic                      m_zero_axis_flag
);

    // Stage map: S1 input regs, S2 squares + angle fold, S3 sum,
    // S4..S47 normalize, S3..S19 CORDIC, S48 products, S49 scaled terms,
    // S50 entry sums, S51 round/saturate = output register.
    localparam int NORM_IN = 3;
    localparam int NORM_OUT = NORM_IN + NORM_LAT;        // 47
    localparam int CS_OUT = 2 + CORDIC_LAT;              // 19
    localparam int CS_DLY = NORM_OUT - CS_OUT;           // 28
    localparam int DEPTH = NORM_OUT + 4;                 // 51

    typedef struct packed {
        logic [NCOMP-1:0] sgn;
        logic             zero;
    } side_t;

    typedef struct packed {
        logic signed [C_W-1:0] c;
        logic signed [C_W-1:0] s;
    } cs_t;

    logic adv;
    logic [DEPTH-1:0] valid_reg, valid_next;

    // S1
    logic signed [IN_W-1:0] ang1_reg;
    logic signed [IN_W-1:0] ax1_reg [NCOMP];
    // S2
    sq_t                   sq2_reg [NCOMP];
    logic [NCOMP-1:0]      sgn2_reg;
    logic signed [CW-1:0]  rz2_reg;
    logic                  neg2_reg;
    logic signed [CW-1:0]  ang_w;
    logic signed [2*IN_W-1:0] sq_full [NCOMP];
    // S3
    sq_t                   sq3_reg [NCOMP];
    sum_t                  sum3_reg;
    sum_t                  sum_w;
    logic [NCOMP-1:0]      sgn3_reg;
    logic                  zero3_reg;
    // side delay lines
    side_t side_reg [NORM_LAT];
    cs_t   cs_reg [CS_DLY];
    logic signed [C_W-1:0] cord_c, cord_s;
    mag_t  mag [NCOMP];
    // S48
    logic signed [N_W-1:0]    n [NCOMP];
    logic signed [PROD_W-1:0] pxx48_reg, pxy48_reg, pxz48_reg;
    logic signed [PROD_W-1:0] pyy48_reg, pyz48_reg, pzz48_reg;
    logic signed [PROD_W-1:0] pxs48_reg, pys48_reg, pzs48_reg;
    logic signed [C_W-1:0]    c48_reg, t48_reg;
    logic                     zero48_reg;
    // S49
    logic signed [Q42_W-1:0]  txx49_reg, txy49_reg, txz49_reg;
    logic signed [Q42_W-1:0]  tyy49_reg, tyz49_reg, tzz49_reg;
    logic signed [Q42_W-1:0]  sx49_reg, sy49_reg, sz49_reg, c49_reg;
    logic                     zero49_reg;
    // S50
    logic signed [Q42_W-1:0]  e50_reg [9];
    logic                     zero50_reg;
    // S51
    logic signed [ENTRY_W-1:0] ent_reg [9];
    logic                      zero_reg;

    // Global advance: move when the output slot is empty or being drained
    assign adv = !valid_reg[DEPTH-1] || m_ready;
    assign s_ready = adv;

    always_comb begin
        valid_next = valid_reg;
        if (adv) begin
            valid_next = {valid_reg[DEPTH-2:0], s_valid};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    // S2 combinational: squares, angle widened to Q.30 and folded into
    // [-pi/2, pi/2] with a negate flag
    assign ang_w = {{(CW-IN_W-ANG_SHIFT){ang1_reg[IN_W-1]}}, ang1_reg, ANG_SHIFT'(0)};

    always_comb begin
        for (int c = 0; c < NCOMP; c++) begin
            sq_full[c] = ax1_reg[c] * ax1_reg[c];
        end
    end

    assign sum_w = SUM_W'(sq2_reg[0]) + SUM_W'(sq2_reg[1]) + SUM_W'(sq2_reg[2]);

    always_ff @(posedge aclk) begin
        if (adv) begin
            // S1
            ang1_reg   <= s_angle;
            ax1_reg[0] <= s_axis_x;
            ax1_reg[1] <= s_axis_y;
            ax1_reg[2] <= s_axis_z;
            // S2
            for (int c = 0; c < NCOMP; c++) begin
                sq2_reg[c]  <= sq_full[c][SQ_W-1:0];
                sgn2_reg[c] <= ax1_reg[c][IN_W-1];
            end
            if (ang_w > HALF_PI_Q30) begin
                rz2_reg  <= ang_w - PI_Q30;
                neg2_reg <= 1'b1;
            end else if (ang_w < -HALF_PI_Q30) begin
                rz2_reg  <= ang_w + PI_Q30;
                neg2_reg <= 1'b1;
            end else begin
                rz2_reg  <= ang_w;
                neg2_reg <= 1'b0;
            end
            // S3
            sq3_reg   <= sq2_reg;
            sum3_reg  <= sum_w;
            sgn3_reg  <= sgn2_reg;
            zero3_reg <= (sum_w == '0);
            // side data rides beside the normalize pipe
            side_reg[0] <= '{sgn: sgn3_reg, zero: zero3_reg};
            for (int i = 1; i < NORM_LAT; i++) begin
                side_reg[i] <= side_reg[i-1];
            end
            cs_reg[0] <= '{c: cord_c, s: cord_s};
            for (int i = 1; i < CS_DLY; i++) begin
                cs_reg[i] <= cs_reg[i-1];
            end
        end
    end

    aar_norm u_norm (
        .aclk (aclk),
        .adv  (adv),
        .sq   (sq3_reg),
        .sum  (sum3_reg),
        .mag  (mag)
    );

    aar_cordic u_cordic (
        .aclk    (aclk),
        .adv     (adv),
        .ang     (rz2_reg),
        .neg     (neg2_reg),
        .cos_q14 (cord_c),
        .sin_q14 (cord_s)
    );

    function automatic logic signed [ENTRY_W-1:0] finish_q14(
        input logic signed [Q42_W-1:0] e
    );
        logic signed [Q42_W-1:0] r;
        r = (e + Q42_W'(1 << 27)) >>> 28;
        if (r > Q42_W'(ONE_Q14)) begin
            return ENTRY_W'(ONE_Q14);
        end else if (r < -Q42_W'(ONE_Q14)) begin
            return -ENTRY_W'(ONE_Q14);
        end
        return ENTRY_W'(r);
    endfunction

    // S48: signed unit axis, pairwise products and axis-times-sine
    always_comb begin
        for (int c = 0; c < NCOMP; c++) begin
            n[c] = side_reg[NORM_LAT-1].sgn[c] ? -N_W'(mag[c]) : N_W'(mag[c]);
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            pxx48_reg  <= PROD_W'(n[0]) * PROD_W'(n[0]);
            pxy48_reg  <= PROD_W'(n[0]) * PROD_W'(n[1]);
            pxz48_reg  <= PROD_W'(n[0]) * PROD_W'(n[2]);
            pyy48_reg  <= PROD_W'(n[1]) * PROD_W'(n[1]);
            pyz48_reg  <= PROD_W'(n[1]) * PROD_W'(n[2]);
            pzz48_reg  <= PROD_W'(n[2]) * PROD_W'(n[2]);
            pxs48_reg  <= PROD_W'(n[0]) * PROD_W'(cs_reg[CS_DLY-1].s);
            pys48_reg  <= PROD_W'(n[1]) * PROD_W'(cs_reg[CS_DLY-1].s);
            pzs48_reg  <= PROD_W'(n[2]) * PROD_W'(cs_reg[CS_DLY-1].s);
            c48_reg    <= cs_reg[CS_DLY-1].c;
            t48_reg    <= ONE_Q14 - cs_reg[CS_DLY-1].c;
            zero48_reg <= side_reg[NORM_LAT-1].zero;
            // S49: everything lifted to Q.42
            txx49_reg  <= Q42_W'(pxx48_reg) * Q42_W'(t48_reg);
            txy49_reg  <= Q42_W'(pxy48_reg) * Q42_W'(t48_reg);
            txz49_reg  <= Q42_W'(pxz48_reg) * Q42_W'(t48_reg);
            tyy49_reg  <= Q42_W'(pyy48_reg) * Q42_W'(t48_reg);
            tyz49_reg  <= Q42_W'(pyz48_reg) * Q42_W'(t48_reg);
            tzz49_reg  <= Q42_W'(pzz48_reg) * Q42_W'(t48_reg);
            sx49_reg   <= Q42_W'(pxs48_reg) <<< 14;
            sy49_reg   <= Q42_W'(pys48_reg) <<< 14;
            sz49_reg   <= Q42_W'(pzs48_reg) <<< 14;
            c49_reg    <= Q42_W'(c48_reg) <<< 28;
            zero49_reg <= zero48_reg;
            // S50: R = c*I + t*nn^T + s*[n]x
            e50_reg[0] <= c49_reg + txx49_reg;
            e50_reg[1] <= txy49_reg - sz49_reg;
            e50_reg[2] <= txz49_reg + sy49_reg;
            e50_reg[3] <= txy49_reg + sz49_reg;
            e50_reg[4] <= c49_reg + tyy49_reg;
            e50_reg[5] <= tyz49_reg - sx49_reg;
            e50_reg[6] <= txz49_reg - sy49_reg;
            e50_reg[7] <= tyz49_reg + sx49_reg;
            e50_reg[8] <= c49_reg + tzz49_reg;
            zero50_reg <= zero49_reg;
            // S51: round to Q.14, clamp to +-1; zero axis forces identity
            for (int i = 0; i < 9; i++) begin
                if (zero50_reg) begin
                    ent_reg[i] <= (i % 4 == 0) ? ENTRY_W'(ONE_Q14) : '0;
                end else begin
                    ent_reg[i] <= finish_q14(e50_reg[i]);
                end
            end
            zero_reg <= zero50_reg;
        end
    end

    assign m_valid          = valid_reg[DEPTH-1];
    assign m_entry_r0_c0    = ent_reg[0];
    assign m_entry_r0_c1    = ent_reg[1];
    assign m_entry_r0_c2    = ent_reg[2];
    assign m_entry_r1_c0    = ent_reg[3];
    assign m_entry_r1_c1    = ent_reg[4];
    assign m_entry_r1_c2    = ent_reg[5];
    assign m_entry_r2_c0    = ent_reg[6];
    assign m_entry_r2_c1    = ent_reg[7];
    assign m_entry_r2_c2    = ent_reg[8];
    assign m_zero_axis_flag = zero_reg;

    // A held pipe keeps every valid bit in place
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        !adv |=> $stable(valid_reg))
        else $error("valid bits moved during a stall");

    // Zero-axis result is the identity (diagonal and r0_c1, r1_c2, r2_c0 checked)
    a_ident: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_zero_axis_flag |->
            m_entry_r0_c0 == ENTRY_W'(ONE_Q14) && m_entry_r1_c1 == ENTRY_W'(ONE_Q14)
            && m_entry_r2_c2 == ENTRY_W'(ONE_Q14) && m_entry_r0_c1 == '0
            && m_entry_r1_c2 == '0 && m_entry_r2_c0 == '0)
        else $error("zero axis without identity");

    // Saturation keeps the diagonal entries r0_c0 and r1_c1 inside +-1
    a_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_entry_r0_c0 <= ENTRY_W'(ONE_Q14) && m_entry_r0_c0 >= -ENTRY_W'(ONE_Q14)
            && m_entry_r1_c1 <= ENTRY_W'(ONE_Q14) && m_entry_r1_c1 >= -ENTRY_W'(ONE_Q14))
        else $error("entry out of range");

    // Unit components never exceed one for a live nonzero axis
    a_norm: assert property (@(posedge aclk) disable iff (!aresetn)
        valid_reg[NORM_OUT-1] && !side_reg[NORM_LAT-1].zero |->
            mag[0] <= NORM_W'(ONE_Q14) && mag[1] <= NORM_W'(ONE_Q14)
            && mag[2] <= NORM_W'(ONE_Q14))
        else $error("normalized component above one");

endmodule

FILE: rtl/aar_norm.sv
// aar_norm: pipelined axis normalization, |v|*2^14/sqrt(S) per component.
// Restoring divider (one bit per stage) then digit-by-digit square root.
// Depends on aar_pkg.
module aar_norm import aar_pkg::*; (
    input  logic aclk,
    input  logic adv,
    input  sq_t  sq [NCOMP],
    input  sum_t sum,
    output mag_t mag [NCOMP]
);

    sum_t             sum_reg [DIV_STEPS-1];
    logic [SUM_W-1:0] rem_reg [NCOMP][DIV_STEPS];
    logic [QUO_W-1:0] q_reg   [NCOMP][DIV_STEPS];
    logic [QUO_W-1:0] sv_reg  [NCOMP][SQRT_STEPS];
    logic [RES_W-1:0] sr_reg  [NCOMP][SQRT_STEPS];

    logic [SUM_W-1:0] rem_next [NCOMP][DIV_STEPS];
    logic [QUO_W-1:0] q_next   [NCOMP][DIV_STEPS];
    logic [QUO_W-1:0] sv_next  [NCOMP][SQRT_STEPS];
    logic [RES_W-1:0] sr_next  [NCOMP][SQRT_STEPS];

    logic [SUM_W:0]   sh     [NCOMP][DIV_STEPS];
    logic [SUM_W:0]   dv     [NCOMP][DIV_STEPS];
    logic             qbit   [NCOMP][DIV_STEPS];
    logic [QUO_W-1:0] vin    [NCOMP][SQRT_STEPS];
    logic [RES_W-1:0] rin    [NCOMP][SQRT_STEPS];
    logic [RES_W-1:0] bitv   [NCOMP][SQRT_STEPS];
    logic [RES_W:0]   trial  [NCOMP][SQRT_STEPS];

    // Divider: partial remainder stays below S, shifted one bit per stage
    always_comb begin
        for (int c = 0; c < NCOMP; c++) begin
            for (int i = 0; i < DIV_STEPS; i++) begin
                if (i == 0) begin
                    sh[c][i] = {2'b00, sq[c]};
                    dv[c][i] = {1'b0, sum};
                end else begin
                    sh[c][i] = {rem_reg[c][i-1], 1'b0};
                    dv[c][i] = {1'b0, sum_reg[i-1]};
                end
                qbit[c][i] = (sh[c][i] >= dv[c][i]);
                if (qbit[c][i]) begin
                    rem_next[c][i] = SUM_W'(sh[c][i] - dv[c][i]);
                end else begin
                    rem_next[c][i] = SUM_W'(sh[c][i]);
                end
                if (i == 0) begin
                    q_next[c][i] = QUO_W'(qbit[c][i]);
                end else begin
                    q_next[c][i] = {q_reg[c][i-1][QUO_W-2:0], qbit[c][i]};
                end
            end
        end
    end

    // Square root: one result bit per stage, test bit walks down two places
    always_comb begin
        for (int c = 0; c < NCOMP; c++) begin
            for (int k = 0; k < SQRT_STEPS; k++) begin
                if (k == 0) begin
                    vin[c][k] = q_reg[c][DIV_STEPS-1];
                    rin[c][k] = '0;
                end else begin
                    vin[c][k] = sv_reg[c][k-1];
                    rin[c][k] = sr_reg[c][k-1];
                end
                bitv[c][k]  = RES_W'(1) << (2 * (SQRT_STEPS - 1 - k));
                trial[c][k] = {1'b0, rin[c][k]} + {1'b0, bitv[c][k]};
                if ({1'b0, vin[c][k]} >= trial[c][k]) begin
                    sv_next[c][k] = vin[c][k] - trial[c][k][QUO_W-1:0];
                    sr_next[c][k] = (rin[c][k] >> 1) + bitv[c][k];
                end else begin
                    sv_next[c][k] = vin[c][k];
                    sr_next[c][k] = rin[c][k] >> 1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            sum_reg[0] <= sum;
            for (int i = 1; i < DIV_STEPS - 1; i++) begin
                sum_reg[i] <= sum_reg[i-1];
            end
            for (int c = 0; c < NCOMP; c++) begin
                for (int i = 0; i < DIV_STEPS; i++) begin
                    rem_reg[c][i] <= rem_next[c][i];
                    q_reg[c][i]   <= q_next[c][i];
                end
                for (int k = 0; k < SQRT_STEPS; k++) begin
                    sv_reg[c][k] <= sv_next[c][k];
                    sr_reg[c][k] <= sr_next[c][k];
                end
            end
        end
    end

    always_comb begin
        for (int c = 0; c < NCOMP; c++) begin
            mag[c] = sr_reg[c][SQRT_STEPS-1][NORM_W-1:0];
        end
    end

endmodule

FILE: rtl/aar_cordic.sv
// aar_cordic: pipelined rotation-mode CORDIC, one stage per iteration,
// then sign fix and rounding to Q.14 sine and cosine. Depends on aar_pkg.
module aar_cordic import aar_pkg::*; (
    input  logic                  aclk,
    input  logic                  adv,
    input  logic signed [CW-1:0]  ang,    // reduced angle, Q.30
    input  logic                  neg,    // negate results after rotation
    output logic signed [C_W-1:0] cos_q14,
    output logic signed [C_W-1:0] sin_q14
);

    logic signed [CW-1:0] cx_reg [CORDIC_STEPS];
    logic signed [CW-1:0] cy_reg [CORDIC_STEPS];
    logic signed [CW-1:0] rz_reg [CORDIC_STEPS];
    logic                 neg_reg [CORDIC_STEPS];

    logic signed [CW-1:0] cx_next [CORDIC_STEPS];
    logic signed [CW-1:0] cy_next [CORDIC_STEPS];
    logic signed [CW-1:0] rz_next [CORDIC_STEPS];
    logic signed [CW-1:0] cx_in   [CORDIC_STEPS];
    logic signed [CW-1:0] cy_in   [CORDIC_STEPS];
    logic signed [CW-1:0] rz_in   [CORDIC_STEPS];

    logic signed [CW-1:0]  cx_fix, cy_fix, cx_rnd, cy_rnd;
    logic signed [C_W-1:0] cos_reg, sin_reg;

    always_comb begin
        for (int k = 0; k < CORDIC_STEPS; k++) begin
            if (k == 0) begin
                cx_in[k] = GAIN_Q30;
                cy_in[k] = '0;
                rz_in[k] = ang;
            end else begin
                cx_in[k] = cx_reg[k-1];
                cy_in[k] = cy_reg[k-1];
                rz_in[k] = rz_reg[k-1];
            end
            if (!rz_in[k][CW-1]) begin
                cx_next[k] = cx_in[k] - (cy_in[k] >>> k);
                cy_next[k] = cy_in[k] + (cx_in[k] >>> k);
                rz_next[k] = rz_in[k] - atan_q30(k);
            end else begin
                cx_next[k] = cx_in[k] + (cy_in[k] >>> k);
                cy_next[k] = cy_in[k] - (cx_in[k] >>> k);
                rz_next[k] = rz_in[k] + atan_q30(k);
            end
        end
    end

    // Half-plane fold, then round half up to Q.14
    always_comb begin
        cx_fix = neg_reg[CORDIC_STEPS-1] ? -cx_reg[CORDIC_STEPS-1] : cx_reg[CORDIC_STEPS-1];
        cy_fix = neg_reg[CORDIC_STEPS-1] ? -cy_reg[CORDIC_STEPS-1] : cy_reg[CORDIC_STEPS-1];
        cx_rnd = (cx_fix + CW'(32768)) >>> 16;
        cy_rnd = (cy_fix + CW'(32768)) >>> 16;
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            for (int k = 0; k < CORDIC_STEPS; k++) begin
                cx_reg[k] <= cx_next[k];
                cy_reg[k] <= cy_next[k];
                rz_reg[k] <= rz_next[k];
            end
            neg_reg[0] <= neg;
            for (int k = 1; k < CORDIC_STEPS; k++) begin
                neg_reg[k] <= neg_reg[k-1];
            end
            cos_reg <= C_W'(cx_rnd);
            sin_reg <= C_W'(cy_rnd);
        end
    end

    assign cos_q14 = cos_reg;
    assign sin_q14 = sin_reg;

endmodule
